// ===== hw/rtl/pip_pkg.sv =====
// shared types and constants for the point-in-polygon test block
// no dependencies; compiled first
package pip_pkg;

    localparam int COORD_W      = 16;
    localparam int MIN_VERTICES = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_diff;
    typedef logic signed [2*COORD_W+1:0] t_prod;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEST   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_RES
    } t_state;

    // one polygon edge handed to the evaluation unit, a -> b in vertex order
    typedef struct packed {
        logic   valid;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

endpackage

// ===== hw/rtl/pip_in_if.sv =====
// input channel: command and coordinates with valid/ready
// depends on pip_pkg
interface pip_in_if;
    import pip_pkg::*;

    logic         valid;
    logic         ready;
    logic [1:0]   command;
    t_coord       coord_x;
    t_coord       coord_y;

    modport source (output valid, output command, output coord_x, output coord_y,
                    input ready);
    modport sink   (input valid, input command, input coord_x, input coord_y,
                    output ready);
endinterface

// ===== hw/rtl/pip_out_if.sv =====
// result channel: inside flag and vertex-count flag with valid/ready
// no dependencies
interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic too_few_vertices;

    modport source (output valid, output inside_res, output too_few_vertices,
                    input ready);
    modport sink   (input valid, input inside_res, input too_few_vertices,
                    output ready);
endinterface

// ===== hw/rtl/point_in_polygon_test.sv =====
// top level of the point-in-polygon test: vertex ring of pip_cell, edge unit,
// control and result register; depends on pip_pkg, pip_in_if, pip_out_if, pip_cell, pip_edge
//
//  channel | dir | fields                               | result
//  i_in    | in  | command, coord_x, coord_y            | one per test command
//  o_out   | out | inside_res, too_few_vertices         | -
//
// a test with fewer than three vertices or a point outside the box goes straight
// to the result; any other test turns the vertex ring one position per cycle past
// the edge unit for a full turn, then waits while the last crossing edges of the
// ring still sit in the edge unit's pipe.
// synchronous active-low reset empties the polygon and zeroes the box.
// an input transfer is taken while a result waits on o_out, except during a test;
// a finished test holds until o_out has taken the previous result.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pip_in_if.sink    i_in,
    pip_out_if.source o_out
);
    import pip_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_step, n_step;
    t_coord           r_min_x, n_min_x;
    t_coord           r_max_x, n_max_x;
    t_coord           r_min_y, n_min_y;
    t_coord           r_max_y, n_max_y;
    t_coord           r_px, n_px;
    t_coord           r_py, n_py;
    t_coord           r_first_x, n_first_x;
    t_coord           r_first_y, n_first_y;
    logic             r_res_inside, n_res_inside;
    logic             r_res_few, n_res_few;
    logic             r_out_valid, n_out_valid;
    logic             r_out_inside, n_out_inside;
    logic             r_out_few, n_out_few;

    logic             in_xfer;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             shift;
    logic             clear;
    logic             outside;
    logic             last_edge;
    logic             edge_busy;
    logic             edge_inside;
    t_edge            edge_in;

    t_coord           w_x [MAX_VERTICES];
    t_coord           w_y [MAX_VERTICES];

    // vertex ring: cell k takes cell k+1 on rotation, so cell 0 sees vertex k at step k
    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        pip_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (wr_en && (wr_idx == IDX_W'(k))),
            .i_load_x (i_in.coord_x),
            .i_load_y (i_in.coord_y),
            .i_shift  (shift),
            .i_next_x (w_x[(k + 1) % MAX_VERTICES]),
            .i_next_y (w_y[(k + 1) % MAX_VERTICES]),
            .o_x      (w_x[k]),
            .o_y      (w_y[k])
        );
    end

    assign last_edge     = CNT_W'(r_step) == (r_count - CNT_W'(1));
    assign edge_in.valid = (r_state == S_RUN) && (CNT_W'(r_step) < r_count);
    assign edge_in.ax    = w_x[0];
    assign edge_in.ay    = w_y[0];
    assign edge_in.bx    = last_edge ? r_first_x : w_x[1];
    assign edge_in.by    = last_edge ? r_first_y : w_y[1];

    pip_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_edge   (edge_in),
        .i_px     (r_px),
        .i_py     (r_py),
        .o_busy   (edge_busy),
        .o_inside (edge_inside)
    );

    assign i_in.ready = r_state == S_IDLE;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign outside    = (i_in.coord_x < r_min_x) || (i_in.coord_x > r_max_x) ||
                        (i_in.coord_y < r_min_y) || (i_in.coord_y > r_max_y);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_min_x      = r_min_x;
        n_max_x      = r_max_x;
        n_min_y      = r_min_y;
        n_max_y      = r_max_y;
        n_px         = r_px;
        n_py         = r_py;
        n_first_x    = r_first_x;
        n_first_y    = r_first_y;
        n_res_inside = r_res_inside;
        n_res_few    = r_res_few;
        n_out_valid  = r_out_valid;
        n_out_inside = r_out_inside;
        n_out_few    = r_out_few;
        wr_en        = 1'b0;
        wr_idx       = '0;
        shift        = 1'b0;
        clear        = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in.command)
                        CMD_START: begin
                            wr_en   = 1'b1;
                            wr_idx  = '0;
                            n_count = CNT_W'(1);
                            n_min_x = i_in.coord_x;
                            n_max_x = i_in.coord_x;
                            n_min_y = i_in.coord_y;
                            n_max_y = i_in.coord_y;
                        end
                        CMD_APPEND: begin
                            if (r_count < CNT_W'(MAX_VERTICES)) begin
                                wr_en   = 1'b1;
                                wr_idx  = r_count[IDX_W-1:0];
                                n_count = r_count + CNT_W'(1);
                                if (r_count == '0) begin
                                    n_min_x = i_in.coord_x;
                                    n_max_x = i_in.coord_x;
                                    n_min_y = i_in.coord_y;
                                    n_max_y = i_in.coord_y;
                                end else begin
                                    if (i_in.coord_x < r_min_x) n_min_x = i_in.coord_x;
                                    if (i_in.coord_x > r_max_x) n_max_x = i_in.coord_x;
                                    if (i_in.coord_y < r_min_y) n_min_y = i_in.coord_y;
                                    if (i_in.coord_y > r_max_y) n_max_y = i_in.coord_y;
                                end
                            end
                        end
                        CMD_TEST: begin
                            n_px = i_in.coord_x;
                            n_py = i_in.coord_y;
                            if (r_count < CNT_W'(MIN_VERTICES)) begin
                                n_res_inside = 1'b0;
                                n_res_few    = 1'b1;
                                n_state      = S_RES;
                            end else if (outside) begin
                                n_res_inside = 1'b0;
                                n_res_few    = 1'b0;
                                n_state      = S_RES;
                            end else begin
                                clear   = 1'b1;
                                n_step  = '0;
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                shift = 1'b1;
                if (r_step == '0) begin
                    n_first_x = w_x[0];
                    n_first_y = w_y[0];
                end
                // a full turn of the ring puts every vertex back in its cell
                if (r_step == IDX_W'(MAX_VERTICES - 1)) begin
                    n_step  = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!edge_busy) begin
                    n_res_inside = edge_inside;
                    n_res_few    = 1'b0;
                    n_state      = S_RES;
                end
            end
            S_RES: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = r_res_inside;
                    n_out_few    = r_res_few;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_min_x     <= '0;
            r_max_x     <= '0;
            r_min_y     <= '0;
            r_max_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_min_x     <= n_min_x;
            r_max_x     <= n_max_x;
            r_min_y     <= n_min_y;
            r_max_y     <= n_max_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_py         <= n_py;
        r_first_x    <= n_first_x;
        r_first_y    <= n_first_y;
        r_res_inside <= n_res_inside;
        r_res_few    <= n_res_few;
        r_out_inside <= n_out_inside;
        r_out_few    <= n_out_few;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.inside_res       = r_out_inside;
    assign o_out.too_few_vertices = r_out_few;

`ifndef SYNTH
    // ring must be back in place whenever new vertices can be written
    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_step == '0)
        else $error("vertex ring not at home position while idle");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    // parity is only taken once the edge pipe is empty
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RES |-> !edge_busy)
        else $error("result taken with edges still in flight");

    a_few_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.command == CMD_TEST && r_count < CNT_W'(MIN_VERTICES)
        |=> r_state == S_RES && r_res_few && !r_res_inside)
        else $error("short polygon test did not flag too few vertices");
`endif

endmodule

// ===== hw/rtl/pip_cell.sv =====
// one vertex cell of the polygon ring: holds x and y, loads a new vertex
// or takes its neighbor's vertex when the ring rotates; depends on pip_pkg
module pip_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  pip_pkg::t_coord i_load_x,
    input  pip_pkg::t_coord i_load_y,
    input  logic            i_shift,
    input  pip_pkg::t_coord i_next_x,
    input  pip_pkg::t_coord i_next_y,
    output pip_pkg::t_coord o_x,
    output pip_pkg::t_coord o_y
);
    import pip_pkg::*;

    t_coord r_x;
    t_coord r_y;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_shift) begin
            r_x <= i_next_x;
            r_y <= i_next_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ===== hw/rtl/pip_edge.sv =====
// edge crossing unit: three-stage pipe (differences, products, compare)
// that accumulates the even-odd parity of a rightward ray; depends on pip_pkg
module pip_edge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  pip_pkg::t_edge  i_edge,
    input  pip_pkg::t_coord i_px,
    input  pip_pkg::t_coord i_py,
    output logic            o_busy,
    output logic            o_inside
);
    import pip_pkg::*;

    logic  r1_valid;
    logic  r1_dy_pos;
    t_diff r1_dy;
    t_diff r1_dx;
    t_diff r1_pxd;
    t_diff r1_pyd;

    logic  r2_valid;
    logic  r2_dy_pos;
    t_prod r2_lhs;
    t_prod r2_rhs;

    logic  r_parity;

    logic  crosses;
    t_diff dy;
    logic  hit;

    // vertex i is b, vertex j is a
    assign crosses = (i_edge.by > i_py) != (i_edge.ay > i_py);
    assign dy      = t_diff'(i_edge.ay) - t_diff'(i_edge.by);
    assign hit     = r2_dy_pos ? (r2_lhs < r2_rhs) : (r2_lhs > r2_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r1_valid <= i_edge.valid && crosses;
            r2_valid <= r1_valid;
            if (i_clear) begin
                r_parity <= 1'b0;
            end else if (r2_valid && hit) begin
                r_parity <= !r_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dy     <= dy;
        r1_dy_pos <= dy > 0;
        r1_dx     <= t_diff'(i_edge.ax) - t_diff'(i_edge.bx);
        r1_pxd    <= t_diff'(i_px) - t_diff'(i_edge.bx);
        r1_pyd    <= t_diff'(i_py) - t_diff'(i_edge.by);
        r2_dy_pos <= r1_dy_pos;
        r2_lhs    <= t_prod'(r1_pxd) * t_prod'(r1_dy);
        r2_rhs    <= t_prod'(r1_dx) * t_prod'(r1_pyd);
    end

    assign o_busy   = r1_valid || r2_valid;
    assign o_inside = r_parity;

endmodule

// ===== sim/point_in_polygon_test_tb.sv =====
`timescale 1ns / 100ps
// testbench for point_in_polygon_test: loads random polygons, probes points, checks results
// depends on pip_pkg, pip_in_if, pip_out_if and the point_in_polygon_test rtl
module point_in_polygon_test_tb;
    import pip_pkg::*;

    localparam int          MAX_VERTS  = 64;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          N_ITEMS    = 550;
    localparam int          FULL_SPAN  = 32768;

    typedef struct packed {
        logic inside_res;
        logic too_few_vertices;
    } t_verdict;

    // shadow copy of the polygon and its box, one verdict queued per test transfer
    class polygon_scoreboard;
        t_coord      vx [MAX_VERTS];
        t_coord      vy [MAX_VERTS];
        int unsigned n_loaded;
        t_coord      lo_x, hi_x, lo_y, hi_y;
        t_verdict    verdicts[$];
        int          errors;

        function new();
            n_loaded = 0;
            lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
            errors = 0;
        endfunction

        function void add_vertex(t_coord x, t_coord y);
            if (n_loaded >= MAX_VERTS) return;
            vx[n_loaded] = x;
            vy[n_loaded] = y;
            if (n_loaded == 0) begin
                lo_x = x; hi_x = x; lo_y = y; hi_y = y;
            end else begin
                if (x < lo_x) lo_x = x;
                if (x > hi_x) hi_x = x;
                if (y < lo_y) lo_y = y;
                if (y > hi_y) hi_y = y;
            end
            n_loaded++;
        endfunction

        function void note_input(logic [1:0] cmd, t_coord x, t_coord y);
            t_verdict    want;
            longint      xi, yi, xj, yj, dx, dy, lhs, rhs;
            int unsigned j;
            bit          odd;
            case (cmd)
                CMD_START: begin
                    n_loaded = 0;
                    add_vertex(x, y);
                end
                CMD_APPEND: add_vertex(x, y);
                CMD_TEST: begin
                    want = '0;
                    if (n_loaded < MIN_VERTICES) begin
                        want.too_few_vertices = 1'b1;
                    end else if (x >= lo_x && x <= hi_x && y >= lo_y && y <= hi_y) begin
                        // even-odd count of edges crossed by a ray to the right
                        odd = 1'b0;
                        j = n_loaded - 1;
                        for (int unsigned i = 0; i < n_loaded; i++) begin
                            xi = vx[i]; yi = vy[i];
                            xj = vx[j]; yj = vy[j];
                            if ((yi > y) != (yj > y)) begin
                                dy  = yj - yi;
                                dx  = xj - xi;
                                lhs = (longint'(x) - xi) * dy;
                                rhs = dx * (longint'(y) - yi);
                                if (dy > 0) begin
                                    if (lhs < rhs) odd = !odd;
                                end else begin
                                    if (lhs > rhs) odd = !odd;
                                end
                            end
                            j = i;
                        end
                        want.inside_res = odd;
                    end
                    verdicts.push_back(want);
                end
                default: ; // unused code leaves everything alone
            endcase
        endfunction

        function void check_result(logic inside_res, logic too_few_vertices);
            t_verdict want;
            if (verdicts.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, inside_res %0b too_few %0b",
                         $time, inside_res, too_few_vertices);
                return;
            end
            want = verdicts.pop_front();
            if (inside_res !== want.inside_res) begin
                errors++;
                $display("%0t: inside_res expected %0b actual %0b",
                         $time, want.inside_res, inside_res);
            end
            if (too_few_vertices !== want.too_few_vertices) begin
                errors++;
                $display("%0t: too_few_vertices expected %0b actual %0b",
                         $time, want.too_few_vertices, too_few_vertices);
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pip_in_if  in_ch ();
    pip_out_if out_ch ();

    polygon_scoreboard sb;

    bit quiet;
    int items_sent;

    // generated polygon, as far as the block keeps it
    int gen_n;
    int gen_x [MAX_VERTS];
    int gen_y [MAX_VERTS];
    int box_lo_x, box_hi_x, box_lo_y, box_hi_y;

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_VERTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_coord rand_near(int center, int span);
        int v;
        v = center + int'($urandom_range(2 * span)) - span;
        if (v < -32768) v = -32768;
        if (v > 32767)  v = 32767;
        return t_coord'(v);
    endfunction

    function automatic t_coord rand_between(int lo, int hi);
        return t_coord'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    task automatic send_item(input logic [1:0] cmd, input t_coord x, input t_coord y);
        int          draw;
        int unsigned gap;
        draw = $urandom_range(99);
        gap  = 0;
        if (!quiet) begin
            if (draw >= 94)      gap = $urandom_range(60, 12);
            else if (draw >= 65) gap = $urandom_range(3, 1);
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.coord_x <= x;
        in_ch.coord_y <= y;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(cmd, x, y);
        items_sent++;
    endtask

    task automatic load_polygon(input int n_verts, input int center_x, input int center_y,
                                input int span);
        t_coord nx, ny;
        for (int v = 0; v < n_verts; v++) begin
            nx = rand_near(center_x, span);
            ny = rand_near(center_y, span);
            if (v < MAX_VERTS) begin
                gen_x[v] = nx;
                gen_y[v] = ny;
                if (v == 0) begin
                    box_lo_x = nx; box_hi_x = nx; box_lo_y = ny; box_hi_y = ny;
                end else begin
                    if (nx < box_lo_x) box_lo_x = nx;
                    if (nx > box_hi_x) box_hi_x = nx;
                    if (ny < box_lo_y) box_lo_y = ny;
                    if (ny > box_hi_y) box_hi_y = ny;
                end
                gen_n = v + 1;
            end
            send_item((v == 0) ? CMD_START : CMD_APPEND, nx, ny);
        end
    endtask

    task automatic probe_polygon(input int n_probes, input int center_x, input int center_y,
                                 input int span);
        int     draw, k;
        t_coord px, py;
        repeat (n_probes) begin
            draw = $urandom_range(99);
            k    = $urandom_range(gen_n - 1);
            px   = rand_between(box_lo_x, box_hi_x);
            py   = rand_between(box_lo_y, box_hi_y);
            if (draw >= 80) begin
                // may land outside the box
                px = rand_near(center_x, span + span / 4 + 2);
                py = rand_near(center_y, span + span / 4 + 2);
            end else if (draw >= 65) begin
                px = gen_x[k];
                if (draw < 72) py = gen_y[k];
            end else if (draw >= 45) begin
                // ray through a vertex height
                py = gen_y[k];
            end
            send_item(CMD_TEST, px, py);
        end
    endtask

    initial begin : result_side
        int draw;
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.inside_res, out_ch.too_few_vertices);
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                draw = $urandom_range(99);
                if (quiet || draw < 85) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    stall_left = (draw < 97) ? $urandom_range(2) : $urandom_range(59, 9);
                end
            end
        end
    end

    initial begin : stimulus
        int draw, sel, span, cx, cy, guard;
        sb            = new();
        quiet         = 1'b0;
        items_sent    = 0;
        gen_n         = 0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_START;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fewer than three vertices, append into an empty polygon, extreme corners
        send_item(CMD_TEST,   0, 0);
        send_item(CMD_APPEND, -32768, -32768);
        send_item(CMD_TEST,   0, 0);
        send_item(CMD_APPEND, 32767, -32768);
        send_item(CMD_TEST,   100, -100);
        send_item(CMD_APPEND, 32767, 32767);
        send_item(CMD_TEST,   100, -100);
        send_item(CMD_TEST,   -32768, 32767);
        send_item(CMD_TEST,   32767, 32767);
        send_item(CMD_TEST,   -32768, -32768);
        send_item(CMD_UNUSED, -1, -1);
        // 10 by 10 square: inside, outside the box, and each side
        send_item(CMD_START,  0, 0);
        send_item(CMD_APPEND, 10, 0);
        send_item(CMD_APPEND, 10, 10);
        send_item(CMD_APPEND, 0, 10);
        send_item(CMD_TEST,   5, 5);
        send_item(CMD_TEST,   11, 5);
        send_item(CMD_TEST,   5, -1);
        send_item(CMD_TEST,   0, 5);
        send_item(CMD_TEST,   10, 5);
        send_item(CMD_TEST,   5, 10);
        send_item(CMD_TEST,   5, 0);

        while (items_sent < N_ITEMS) begin
            draw  = $urandom_range(99);
            quiet = ($urandom_range(3) == 0);
            sel   = $urandom_range(2);
            span  = (sel == 0) ? 6 : (sel == 1) ? 300 : FULL_SPAN;
            cx    = (span == FULL_SPAN) ? 0 : int'($urandom_range(60000)) - 30000;
            cy    = (span == FULL_SPAN) ? 0 : int'($urandom_range(60000)) - 30000;
            if (draw < 5) begin
                // fill to capacity or past it
                load_polygon($urandom_range(70, 64), cx, cy, span);
                probe_polygon(4, cx, cy, span);
            end else if (draw < 13) begin
                repeat ($urandom_range(4, 1))
                    send_item(2'($urandom_range(3)), t_coord'($urandom), t_coord'($urandom));
            end else if (draw < 20) begin
                load_polygon($urandom_range(2, 1), cx, cy, span);
                probe_polygon(2, cx, cy, span);
            end else begin
                load_polygon(($urandom_range(99) < 10) ? $urandom_range(64, 13)
                                                       : $urandom_range(8, 3),
                             cx, cy, span);
                probe_polygon($urandom_range(8, 2), cx, cy, span);
            end
        end
        in_ch.valid <= 1'b0;
        quiet = 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (MAX_VERTS + 16) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending());
        end
        if (sb.errors == 0) begin
            $display("point_in_polygon_test verification clean");
        end else begin
            $display("point_in_polygon_test verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("point_in_polygon_test verification failed");
        $finish;
    end

endmodule
